>>> rtl/core/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared types, codes and helpers for the find-and-replace core
// Channel payloads, register indexes, window cell controls and byte helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  // Default sizes of the window and of the replacement sequence
  localparam int unsigned MAX_PATTERN_DEF     = 16;
  localparam int unsigned MAX_REPLACEMENT_DEF = 16;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LEN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CASE_SENSITIVE   = 3'd6;

  localparam int unsigned LEN_FIELD_W = 5;

  // ASCII upper-case letter range and the fold offset
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_CASE_OFS = 8'h20;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } sfr_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic       any_match;
  } sfr_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          value;
  } sfr_cfg_t;

  // Window cell operations
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT
  } sfr_cell_op_t;

  // Controls broadcast along the row of window cells
  typedef struct packed {
    sfr_cell_op_t op;
    logic         pre_shift;
    logic         fold_en;
    logic [7:0]   in_byte;
  } sfr_cell_ctrl_t;

  // Byte idx of a two-word register pair; beyond the pair reads as zero
  function automatic logic [7:0] pick_byte(input logic [63:0] lo, input logic [63:0] hi,
                                           input logic [7:0] idx);
    logic [7:0] b;
    b = '0;
    if (idx < 8'd8) begin
      b = lo[{idx[2:0], 3'b000} +: 8];
    end else if (idx < 8'd16) begin
      b = hi[{idx[2:0], 3'b000} +: 8];
    end
    return b;
  endfunction

  // Lower-case ASCII letters when folding is enabled
  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
    logic [7:0] r;
    r = b;
    if (en && (b inside {[ASCII_UPPER_A:ASCII_UPPER_Z]})) begin
      r = b + ASCII_CASE_OFS;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/sfr_stream_if.sv
// ----------------------------------------------------------------------------
// sfr_stream_if: valid/ready channel
// One transfer per rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sfr_cell.sv
// ----------------------------------------------------------------------------
// sfr_cell: one byte cell of the match window
// Holds one window byte, compares it with its pattern byte and shifts it on.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_cell (
  input  wire logic                    clk,
  input  wire sfr_pkg::sfr_cell_ctrl_t ctrl,
  input  wire logic                    sel,         // this cell is the write position
  input  wire logic                    en,          // cell lies inside the pattern
  input  wire logic [7:0]              pat_byte,
  input  wire logic [7:0]              right_pass,  // neighbour towards the newer end
  output logic      [7:0]              pass,
  output logic                         match
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;
  logic [7:0] cmp_byte;

  // Present the incoming byte in place of the stored one at the write position
  assign pass     = sel ? ctrl.in_byte : byte_r;
  assign cmp_byte = ctrl.pre_shift ? right_pass : pass;
  assign match    = !en || (sfr_pkg::fold_byte(cmp_byte, ctrl.fold_en) == pat_byte);

  always_comb begin
    byte_nxt = byte_r;
    case (ctrl.op)
      sfr_pkg::CELL_LOAD: begin
        if (sel) begin
          byte_nxt = ctrl.in_byte;
        end
      end
      sfr_pkg::CELL_SHIFT: byte_nxt = right_pass;
      default:             byte_nxt = byte_r;
    endcase
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/core/sfr_window.sv
// ----------------------------------------------------------------------------
// sfr_window: row of window cells
// Chains the cells oldest first and reduces their compare results to a hit.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_window #(
  parameter int unsigned MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
  input  wire logic                    clk,
  input  wire sfr_pkg::sfr_cell_ctrl_t ctrl,
  input  wire logic [MAX_PATTERN:0]    sel,
  input  wire logic [MAX_PATTERN-1:0]  en,
  input  wire logic [63:0]             pattern_low,
  input  wire logic [63:0]             pattern_high,
  output logic                         hit,
  output logic      [7:0]              oldest
);

  logic [7:0]             pass_w [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0] match_w;

  // Virtual cell past the end: the incoming byte when the window is full
  assign pass_w[MAX_PATTERN] = sel[MAX_PATTERN] ? ctrl.in_byte : 8'h00;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    sfr_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .sel        (sel[i]),
      .en         (en[i]),
      .pat_byte   (sfr_pkg::pick_byte(pattern_low, pattern_high, 8'(i))),
      .right_pass (pass_w[i+1]),
      .pass       (pass_w[i]),
      .match      (match_w[i])
    );
  end

  assign hit    = &match_w;
  assign oldest = pass_w[0];

endmodule

`default_nettype wire

>>> rtl/core/stream_find_and_replace_core.sv
// ----------------------------------------------------------------------------
// stream_find_and_replace_core: streaming literal find-and-replace
// Greedy, non-overlapping replacement of a configured literal in a byte stream.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                                   Transfer
//  in_chan   in   text_byte[8], end_of_text                 one text byte
//  out_chan  out  out_byte[8], byte_valid, last, any_match  one result
//  cfg_chan  in   index[3], value[64]                       one register write
//
//  Cycles: one text byte per cycle while bytes pass through or miss.
//  A hit emits its replacement one byte a cycle, and the input stalls until
//  the last replacement byte is emitted (not at all for an empty replacement).
//  End of text flushes the window one byte a cycle; a shortened pattern trims the
//  window, holding the input, before the next byte is compared. Reset: synchronous,
//  active low; control registers take their reset values at once, no clearing pass;
//  data registers are not reset. Window bytes beyond the fill count are never read.
//  Stalls: one held input item and one output register; out_chan back-pressure
//  holds the working stage, and in_chan is ready whenever the hold is free.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_find_and_replace_core #(
  parameter int unsigned MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
  parameter int unsigned MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  sfr_stream_if.sink   in_chan,
  sfr_stream_if.source out_chan,
  sfr_stream_if.sink   cfg_chan
);

  localparam int unsigned LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int unsigned RLEN_W = $clog2(MAX_REPLACEMENT + 1);
  localparam int unsigned PCL_W  =
    (LEN_W > sfr_pkg::LEN_FIELD_W) ? LEN_W : sfr_pkg::LEN_FIELD_W;
  localparam int unsigned RCL_W  =
    (RLEN_W > sfr_pkg::LEN_FIELD_W) ? RLEN_W : sfr_pkg::LEN_FIELD_W;

  typedef enum logic [1:0] {
    PH_MAIN,    // trim, insert and compare
    PH_REPL,    // stream the rest of a replacement
    PH_FLUSH    // drain the window at end of text
  } phase_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [63:0]                     pat_lo_r;
  logic [63:0]                     pat_hi_r;
  logic [sfr_pkg::LEN_FIELD_W-1:0] pat_len_r;
  logic [63:0]                     rep_lo_r;
  logic [63:0]                     rep_hi_r;
  logic [sfr_pkg::LEN_FIELD_W-1:0] rep_len_r;
  logic                            case_sens_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r    <= '0;
      pat_hi_r    <= '0;
      pat_len_r   <= sfr_pkg::LEN_FIELD_W'(1);
      rep_lo_r    <= '0;
      rep_hi_r    <= '0;
      rep_len_r   <= '0;
      case_sens_r <= 1'b1;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      case (cfg_chan.data.index)
        sfr_pkg::REG_PATTERN_LOW:      pat_lo_r  <= cfg_chan.data.value;
        sfr_pkg::REG_PATTERN_HIGH:     pat_hi_r  <= cfg_chan.data.value;
        sfr_pkg::REG_PATTERN_LENGTH:
          pat_len_r <= cfg_chan.data.value[sfr_pkg::LEN_FIELD_W-1:0];
        sfr_pkg::REG_REPLACEMENT_LOW:  rep_lo_r  <= cfg_chan.data.value;
        sfr_pkg::REG_REPLACEMENT_HIGH: rep_hi_r  <= cfg_chan.data.value;
        sfr_pkg::REG_REPLACEMENT_LEN:
          rep_len_r <= cfg_chan.data.value[sfr_pkg::LEN_FIELD_W-1:0];
        sfr_pkg::REG_CASE_SENSITIVE:   case_sens_r <= cfg_chan.data.value[0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Effective lengths: a zero pattern counts as one; each saturates at its own maximum
  logic [PCL_W-1:0]  plen_wide;
  logic [RCL_W-1:0]  rlen_wide;
  logic [LEN_W-1:0]  plen;
  logic [RLEN_W-1:0] rlen;

  always_comb begin
    plen_wide = PCL_W'(pat_len_r);
    rlen_wide = RCL_W'(rep_len_r);
    if (plen_wide == '0) begin
      plen = LEN_W'(1);
    end else if (plen_wide > PCL_W'(MAX_PATTERN)) begin
      plen = LEN_W'(MAX_PATTERN);
    end else begin
      plen = plen_wide[LEN_W-1:0];
    end
    if (rlen_wide > RCL_W'(MAX_REPLACEMENT)) begin
      rlen = RLEN_W'(MAX_REPLACEMENT);
    end else begin
      rlen = rlen_wide[RLEN_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Hold stage, working state and output register
  // --------------------------------------------------------------------------
  logic              hold_v_r;
  sfr_pkg::sfr_in_t  hold_r;
  phase_t            phase_r,  phase_nxt;
  logic [LEN_W-1:0]  fill_r,   fill_nxt;
  logic              match_seen_r, match_seen_nxt;
  logic [RLEN_W-1:0] ridx_r,   ridx_nxt;
  logic              out_v_r;
  sfr_pkg::sfr_out_t out_r;

  logic in_rdy;
  logic in_xfer;
  logic out_free;
  logic go;
  logic done;

  assign out_free = !out_v_r || out_chan.ready;
  assign go       = hold_v_r && out_free;
  assign in_rdy   = !hold_v_r || done;
  assign in_xfer  = in_chan.valid && in_rdy;

  assign in_chan.ready  = in_rdy;
  assign out_chan.valid = out_v_r;
  assign out_chan.data  = out_r;

  // --------------------------------------------------------------------------
  // Window row
  // --------------------------------------------------------------------------
  sfr_pkg::sfr_cell_ctrl_t cell_ctrl;
  sfr_pkg::sfr_cell_op_t   cell_op;
  logic [MAX_PATTERN:0]    wr_sel;
  logic [MAX_PATTERN-1:0]  pat_en;
  logic                    pre_shift;
  logic                    win_hit;
  logic [7:0]              win_oldest;

  // Window over-full after a shorter pattern was configured: trim first
  assign pre_shift = (fill_r >= plen);

  always_comb begin
    for (int k = 0; k <= MAX_PATTERN; k++) begin
      wr_sel[k] = (fill_r == LEN_W'(k));
    end
    for (int k = 0; k < MAX_PATTERN; k++) begin
      pat_en[k] = (LEN_W'(k) < plen);
    end
  end

  assign cell_ctrl.op        = cell_op;
  assign cell_ctrl.pre_shift = pre_shift;
  assign cell_ctrl.fold_en   = !case_sens_r;
  assign cell_ctrl.in_byte   = hold_r.text_byte;

  sfr_window #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_window (
    .clk          (clk),
    .ctrl         (cell_ctrl),
    .sel          (wr_sel),
    .en           (pat_en),
    .pattern_low  (pat_lo_r),
    .pattern_high (pat_hi_r),
    .hit          (win_hit),
    .oldest       (win_oldest)
  );

  // --------------------------------------------------------------------------
  // Sequencer: at most one result per cycle, last flag known when it is made
  // --------------------------------------------------------------------------
  logic       emit;
  logic [7:0] em_byte;
  logic       em_valid;
  logic       em_last;
  logic       em_any;
  logic [7:0] rep_cur;
  logic       eot;
  logic       full_next;

  assign eot       = hold_r.end_of_text;
  assign full_next = ((fill_r + LEN_W'(1)) == plen);
  assign rep_cur   = sfr_pkg::pick_byte(rep_lo_r, rep_hi_r, 8'(ridx_r));

  always_comb begin
    emit           = 1'b0;
    em_byte        = win_oldest;
    em_valid       = 1'b1;
    em_last        = 1'b0;
    em_any         = 1'b0;
    done           = 1'b0;
    fill_nxt       = fill_r;
    phase_nxt      = phase_r;
    match_seen_nxt = match_seen_r;
    ridx_nxt       = ridx_r;
    cell_op        = sfr_pkg::CELL_HOLD;

    if (go) begin
      case (phase_r)
        PH_MAIN: begin
          if (pre_shift) begin
            // Trim the oldest byte; the cells already see the post-trim window
            emit    = 1'b1;
            cell_op = sfr_pkg::CELL_SHIFT;
            if ((fill_r == plen) && win_hit && (rlen == '0)) begin
              // Last trim plus a hit with empty replacement: finish here
              fill_nxt = '0;
              done     = 1'b1;
              if (eot) begin
                em_last        = 1'b1;
                em_any         = 1'b1;
                match_seen_nxt = 1'b0;
              end else begin
                match_seen_nxt = 1'b1;
              end
            end else begin
              fill_nxt = fill_r - LEN_W'(1);
            end
          end else if (!full_next) begin
            // Window not yet full: just append
            cell_op  = sfr_pkg::CELL_LOAD;
            fill_nxt = fill_r + LEN_W'(1);
            if (eot) begin
              phase_nxt = PH_FLUSH;
            end else begin
              done = 1'b1;
            end
          end else if (!win_hit) begin
            // Miss: pass the oldest byte on, append the new one
            emit    = 1'b1;
            cell_op = sfr_pkg::CELL_SHIFT;
            if (eot && (fill_r != '0)) begin
              phase_nxt = PH_FLUSH;
            end else begin
              done = 1'b1;
              if (eot) begin
                em_last        = 1'b1;
                em_any         = match_seen_r;
                match_seen_nxt = 1'b0;
              end
            end
          end else begin
            // Hit: drop the window, start the replacement
            fill_nxt       = '0;
            match_seen_nxt = 1'b1;
            if (rlen == '0) begin
              done = 1'b1;
              if (eot) begin
                emit           = 1'b1;
                em_byte        = 8'h00;
                em_valid       = 1'b0;
                em_last        = 1'b1;
                em_any         = 1'b1;
                match_seen_nxt = 1'b0;
              end
            end else begin
              emit    = 1'b1;
              em_byte = rep_cur;
              if (rlen == RLEN_W'(1)) begin
                done = 1'b1;
                if (eot) begin
                  em_last        = 1'b1;
                  em_any         = 1'b1;
                  match_seen_nxt = 1'b0;
                end
              end else begin
                ridx_nxt  = RLEN_W'(1);
                phase_nxt = PH_REPL;
              end
            end
          end
        end

        PH_REPL: begin
          emit    = 1'b1;
          em_byte = rep_cur;
          if (ridx_r == (rlen - RLEN_W'(1))) begin
            ridx_nxt  = '0;
            phase_nxt = PH_MAIN;
            done      = 1'b1;
            if (eot) begin
              em_last        = 1'b1;
              em_any         = 1'b1;
              match_seen_nxt = 1'b0;
            end
          end else begin
            ridx_nxt = ridx_r + RLEN_W'(1);
          end
        end

        PH_FLUSH: begin
          emit     = 1'b1;
          cell_op  = sfr_pkg::CELL_SHIFT;
          fill_nxt = fill_r - LEN_W'(1);
          if (fill_r == LEN_W'(1)) begin
            phase_nxt      = PH_MAIN;
            done           = 1'b1;
            em_last        = 1'b1;
            em_any         = match_seen_r;
            match_seen_nxt = 1'b0;
          end
        end

        default: phase_nxt = PH_MAIN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_MAIN;
      fill_r       <= '0;
      match_seen_r <= 1'b0;
      ridx_r       <= '0;
      hold_v_r     <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      fill_r       <= fill_nxt;
      match_seen_r <= match_seen_nxt;
      ridx_r       <= ridx_nxt;
      // Take a new item whenever the hold is empty or finishes this cycle
      hold_v_r     <= in_xfer || (hold_v_r && !done);
      if (out_free) begin
        out_v_r <= emit;
      end
    end
    if (in_xfer) begin
      hold_r <= in_chan.data;
    end
    if (out_free && emit) begin
      out_r.out_byte   <= em_byte;
      out_r.byte_valid <= em_valid;
      out_r.last       <= em_last;
      out_r.any_match  <= em_any;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_repl_after_hit : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_REPL) |-> ((fill_r == '0) && match_seen_r && hold_v_r))
    else $error("replacement streaming without a consumed window");

  a_flush_at_end : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_FLUSH) |-> (hold_v_r && hold_r.end_of_text && (fill_r != '0)))
    else $error("window flush outside end of text");

  a_any_only_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.any_match) |-> out_r.last)
    else $error("any_match raised on a result that is not last");

  a_marker_on_hit : assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_r.byte_valid) |-> (out_r.last && out_r.any_match))
    else $error("bare end marker without an empty-replacement hit");

  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (go && !pre_shift && (phase_r == PH_MAIN)) |=> (fill_r < LEN_W'(MAX_PATTERN)))
    else $error("window fill beyond the pattern after an insert");

endmodule

`default_nettype wire

>>> test/stream_find_and_replace_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_and_replace_core_test: self-checking bench for the replace core
// Walks a directed table of register writes and text bytes, then random texts
// built around the configured pattern. Every result is checked against the in-bench
// replacement predictor or a typed-in result, mostly with random idling on both sides.
// ----------------------------------------------------------------------------

module stream_find_and_replace_core_test;

  localparam int unsigned RANDOM_ITEMS = 380;
  localparam int unsigned DRAIN_TAIL   = 40;      // covers a byte that emits nothing
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned WINDOW_MAX   = 16;
  localparam logic [sfr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;  // decoded by nobody

  typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;

  // One step of the directed part: a register write or a text byte. A byte row
  // may carry its single expected result typed in; otherwise it is predicted.
  typedef struct {
    row_kind_t                     kind;
    logic [sfr_pkg::CFG_IDX_W-1:0] idx;
    logic [63:0]                   value;
    logic                          eot;
    bit                            typed;
    sfr_pkg::sfr_out_t             want;
  } plan_row_t;

  localparam int unsigned NPLAN = 31;

  plan_row_t dir_plan [NPLAN] = '{
    // reset settings: pattern is a single NUL, replacement empty
    '{ROW_BYTE,  '0, 64'h00, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1}},  // bare end marker
    '{ROW_BYTE,  '0, 64'hFF, 1'b1, 1'b1, {8'hFF, 1'b1, 1'b1, 1'b0}},
    // "abc" -> "XY", case folded
    '{ROW_WRITE, sfr_pkg::REG_CASE_SENSITIVE,   64'h0,      1'b0, 1'b0, '0},
    '{ROW_WRITE, sfr_pkg::REG_PATTERN_LOW,      64'h636261, 1'b0, 1'b0, '0},
    '{ROW_WRITE, sfr_pkg::REG_PATTERN_LENGTH,   64'd3,      1'b0, 1'b0, '0},
    '{ROW_WRITE, sfr_pkg::REG_REPLACEMENT_LOW,  64'h5958,   1'b0, 1'b0, '0},
    '{ROW_WRITE, sfr_pkg::REG_REPLACEMENT_LEN,  64'd2,      1'b0, 1'b0, '0},
    '{ROW_BYTE,  '0, 64'h41, 1'b0, 1'b0, '0},   // A
    '{ROW_BYTE,  '0, 64'h62, 1'b0, 1'b0, '0},   // b
    '{ROW_BYTE,  '0, 64'h43, 1'b1, 1'b0, '0},   // C, end of text on a hit
    '{ROW_BYTE,  '0, 64'h61, 1'b0, 1'b0, '0},   // a
    '{ROW_BYTE,  '0, 64'h42, 1'b1, 1'b0, '0},   // B, short window flushed
    '{ROW_BYTE,  '0, 64'h78, 1'b0, 1'b0, '0},   // x
    '{ROW_BYTE,  '0, 64'h61, 1'b0, 1'b0, '0},
    '{ROW_BYTE,  '0, 64'h62, 1'b0, 1'b0, '0},
    '{ROW_BYTE,  '0, 64'h63, 1'b0, 1'b0, '0},
    '{ROW_BYTE,  '0, 64'h61, 1'b1, 1'b0, '0},
    // oversized lengths saturate to the full window and replacement
    '{ROW_WRITE, sfr_pkg::REG_PATTERN_LOW,      64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
    '{ROW_WRITE, sfr_pkg::REG_PATTERN_HIGH,     64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
    '{ROW_WRITE, sfr_pkg::REG_PATTERN_LENGTH,   64'd31,                  1'b0, 1'b0, '0},
    '{ROW_WRITE, sfr_pkg::REG_REPLACEMENT_LOW,  64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, '0},
    '{ROW_WRITE, sfr_pkg::REG_REPLACEMENT_HIGH, 64'hFEDC_BA98_7654_3210, 1'b0, 1'b0, '0},
    '{ROW_WRITE, sfr_pkg::REG_REPLACEMENT_LEN,  64'd31,                  1'b0, 1'b0, '0},
    '{ROW_BYTE,  '0, 64'hFF, 1'b0, 1'b0, '0},
    '{ROW_BYTE,  '0, 64'hFF, 1'b0, 1'b0, '0},
    '{ROW_BYTE,  '0, 64'hFF, 1'b0, 1'b0, '0},
    // shorten the pattern with three bytes held: trim, then hit
    '{ROW_WRITE, sfr_pkg::REG_PATTERN_LENGTH,   64'd2,   1'b0, 1'b0, '0},
    '{ROW_BYTE,  '0, 64'hFF, 1'b0, 1'b0, '0},
    // zero pattern length behaves as one
    '{ROW_WRITE, sfr_pkg::REG_PATTERN_LENGTH,   64'd0,   1'b0, 1'b0, '0},
    '{ROW_BYTE,  '0, 64'hFF, 1'b1, 1'b0, '0},
    '{ROW_BYTE,  '0, 64'h00, 1'b1, 1'b1, {8'h00, 1'b1, 1'b1, 1'b0}}
  };

  logic clk;
  logic rst_n;

  sfr_stream_if #(.payload_t(sfr_pkg::sfr_in_t))  in_chan  ();
  sfr_stream_if #(.payload_t(sfr_pkg::sfr_out_t)) out_chan ();
  sfr_stream_if #(.payload_t(sfr_pkg::sfr_cfg_t)) cfg_chan ();

  stream_find_and_replace_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Predictor copy of the registers, at their reset values
  logic [63:0] pat_lo   = '0;
  logic [63:0] pat_hi   = '0;
  logic [63:0] rep_lo   = '0;
  logic [63:0] rep_hi   = '0;
  logic [4:0]  pat_len  = 5'd1;
  logic [4:0]  rep_len  = '0;
  logic        case_sens = 1'b1;

  // Predictor copy of the window
  logic [7:0]  win [WINDOW_MAX] = '{default: '0};
  int unsigned win_fill = 0;
  bit          seen = 1'b0;

  sfr_pkg::sfr_out_t step_results [$];   // results of the byte just transferred
  sfr_pkg::sfr_out_t due [$];            // results still to come out, oldest first

  int unsigned in_idle_pct   = 35;
  int unsigned out_stall_pct = 35;
  int unsigned n_items       = 0;
  int unsigned n_checked     = 0;
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Byte i of a register pair; past the pair reads as zero
  function automatic logic [7:0] byte_of(logic [63:0] lo, logic [63:0] hi, int unsigned i);
    logic [127:0] both;
    both = {hi, lo};
    if (i >= 16) return 8'h00;
    return both[8*i +: 8];
  endfunction

  // What the compare sees of a window byte: A..Z folded down when case-blind
  function automatic logic [7:0] compare_form(logic [7:0] b);
    if (!case_sens && b >= "A" && b <= "Z") return b + 8'h20;
    return b;
  endfunction

  // Pattern length in use: zero counts as one, saturate at the window size
  function automatic int unsigned eff_pat_len();
    if (pat_len == 0) return 1;
    if (pat_len > WINDOW_MAX) return WINDOW_MAX;
    return pat_len;
  endfunction

  function automatic void emit(logic [7:0] b, logic has_data);
    step_results.push_back({b, has_data, 1'b0, 1'b0});
  endfunction

  function automatic logic [7:0] pop_oldest();
    logic [7:0] b;
    b = win[0];
    for (int i = 1; i < win_fill; i++) win[i-1] = win[i];
    if (win_fill > 0) win_fill--;
    return b;
  endfunction

  // Advance the window by one text byte and collect the results it causes
  function automatic void find_replace_step(logic [7:0] b, logic eot);
    int unsigned       plen;
    int unsigned       rlen;
    bit                hit;
    sfr_pkg::sfr_out_t tail;
    plen = eff_pat_len();
    rlen = (rep_len > WINDOW_MAX) ? WINDOW_MAX : rep_len;
    // a shortened pattern trims the window before the new byte goes in
    while (win_fill >= plen) emit(pop_oldest(), 1'b1);
    win[win_fill] = b;
    win_fill++;
    if (win_fill == plen) begin
      hit = 1'b1;
      for (int i = 0; i < plen; i++) begin
        if (compare_form(win[i]) != byte_of(pat_lo, pat_hi, i)) hit = 1'b0;
      end
      if (hit) begin
        seen = 1'b1;
        for (int i = 0; i < rlen; i++) emit(byte_of(rep_lo, rep_hi, i), 1'b1);
        win_fill = 0;
      end else begin
        emit(pop_oldest(), 1'b1);
      end
    end
    if (eot) begin
      while (win_fill > 0) emit(pop_oldest(), 1'b1);
      if (step_results.size() == 0) emit(8'h00, 1'b0);
      tail = step_results.pop_back();
      tail.last = 1'b1;
      tail.any_match = seen;
      step_results.push_back(tail);
      seen = 1'b0;
      win_fill = 0;
    end
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one text byte, with random idle cycles ahead of it. On the transfer,
  // queue its expected results: the typed-in one if given, else the predicted.
  task automatic send_byte(logic [7:0] b, logic eot, bit typed, sfr_pkg::sfr_out_t want);
    cfg_chan.valid <= 1'b0;
    while ($urandom_range(99) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= {b, eot};
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    step_results.delete();
    find_replace_step(b, eot);
    if (typed) begin
      due.push_back(want);
    end else begin
      foreach (step_results[i]) due.push_back(step_results[i]);
    end
    n_items++;
  endtask

  // Hold the write until it is taken; the valid stays up for a following write
  // and is dropped by whoever drives next.
  task automatic write_reg(logic [sfr_pkg::CFG_IDX_W-1:0] idx, logic [63:0] v);
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= {idx, v};
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    case (idx)
      sfr_pkg::REG_PATTERN_LOW:      pat_lo    = v;
      sfr_pkg::REG_PATTERN_HIGH:     pat_hi    = v;
      sfr_pkg::REG_PATTERN_LENGTH:   pat_len   = v[4:0];
      sfr_pkg::REG_REPLACEMENT_LOW:  rep_lo    = v;
      sfr_pkg::REG_REPLACEMENT_HIGH: rep_hi    = v;
      sfr_pkg::REG_REPLACEMENT_LEN:  rep_len   = v[4:0];
      sfr_pkg::REG_CASE_SENSITIVE:   case_sens = v[0];
      default: ;
    endcase
  endtask

  // Wait for every expected result, then give a byte still being absorbed
  // time to settle before any register changes.
  task automatic drain();
    in_chan.valid  <= 1'b0;
    cfg_chan.valid <= 1'b0;
    while (due.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // One random setting followed by texts built mostly from the pattern itself,
  // so that hits, near misses and case variants turn up often. When the budget
  // runs out mid-text the window is left loaded for the next setting.
  task automatic random_phase(int unsigned budget);
    logic [127:0] pat;
    logic [63:0]  v;
    logic [7:0]   b;
    logic [7:0]   text [$];
    logic [4:0]   plen_w;
    logic [4:0]   rlen_w;
    int unsigned  k;
    drain();
    case ($urandom_range(7))
      0:       plen_w = 5'd0;
      1:       plen_w = 5'd16;
      2:       plen_w = 5'd31;
      3:       plen_w = 5'($urandom_range(31));
      default: plen_w = 5'($urandom_range(4, 1));
    endcase
    case ($urandom_range(7))
      0:       rlen_w = 5'd0;
      1:       rlen_w = 5'd16;
      2:       rlen_w = 5'd31;
      3:       rlen_w = 5'($urandom_range(31));
      default: rlen_w = 5'($urandom_range(4));
    endcase
    // mostly lower-case letters from a tiny alphabet, some capitals and noise
    for (int i = 0; i < 16; i++) begin
      k = $urandom_range(9);
      if (k < 6)      pat[8*i +: 8] = 8'("a" + $urandom_range(2));
      else if (k < 8) pat[8*i +: 8] = 8'("A" + $urandom_range(2));
      else            pat[8*i +: 8] = 8'($urandom);
    end
    write_reg(sfr_pkg::REG_PATTERN_LOW, pat[63:0]);
    write_reg(sfr_pkg::REG_PATTERN_HIGH, pat[127:64]);
    v = rand64();
    v[4:0] = plen_w;
    write_reg(sfr_pkg::REG_PATTERN_LENGTH, v);
    write_reg(sfr_pkg::REG_REPLACEMENT_LOW, rand64());
    write_reg(sfr_pkg::REG_REPLACEMENT_HIGH, rand64());
    v = rand64();
    v[4:0] = rlen_w;
    write_reg(sfr_pkg::REG_REPLACEMENT_LEN, v);
    write_reg(sfr_pkg::REG_CASE_SENSITIVE, rand64());
    if ($urandom_range(3) == 0) write_reg(REG_UNUSED, rand64());

    while (budget > 0) begin
      text.delete();
      repeat ($urandom_range(6, 1)) begin
        k = $urandom_range(9);
        if (k < 5) begin
          for (int i = 0; i < eff_pat_len(); i++) begin
            b = byte_of(pat_lo, pat_hi, i);
            // flip letters to capitals now and then when the compare is case-blind
            if (!case_sens && b >= "a" && b <= "z" && $urandom_range(1)) b = b - 8'h20;
            text.push_back(b);
          end
        end else if (k < 8) begin
          text.push_back(byte_of(pat_lo, pat_hi, $urandom_range(eff_pat_len() - 1)));
        end else begin
          text.push_back(8'($urandom));
        end
      end
      foreach (text[i]) begin
        if (budget == 0) break;
        send_byte(text[i], i == text.size() - 1, 1'b0, '0);
        budget--;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, compare each transfer with the oldest
  // expectation
  // --------------------------------------------------------------------------

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_sink
    sfr_pkg::sfr_out_t head;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (due.size() == 0) begin
        $display("%0t: result with nothing expected, got %p", $time, out_chan.data);
        mismatches++;
      end else begin
        head = due.pop_front();
        check_field("out_byte", head.out_byte, out_chan.data.out_byte);
        check_field("byte_valid", head.byte_valid, out_chan.data.byte_valid);
        check_field("last", head.last, out_chan.data.last);
        check_field("any_match", head.any_match, out_chan.data.any_match);
        n_checked++;
      end
    end
    out_chan.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Guard against a hang
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: gave up after %0d cycles, %0d results outstanding",
               $time, CYCLE_LIMIT, due.size());
      $display("[stream_find_and_replace_core] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  initial begin : stimulus
    int unsigned rand_items;
    int unsigned phase;
    int unsigned budget;
    in_chan.valid  = 1'b0;
    in_chan.data   = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.data  = '0;
    rst_n          = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; each write waits until the block has gone quiet
    foreach (dir_plan[r]) begin
      if (dir_plan[r].kind == ROW_WRITE) begin
        drain();
        write_reg(dir_plan[r].idx, dir_plan[r].value);
      end else begin
        send_byte(dir_plan[r].value[7:0], dir_plan[r].eot, dir_plan[r].typed,
                  dir_plan[r].want);
      end
    end

    // random settings; a run of phases in the middle goes without any idling
    rand_items = 0;
    phase = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if (phase >= 6 && phase < 11) begin
        in_idle_pct   = 0;
        out_stall_pct = 0;
      end else begin
        in_idle_pct   = 35;
        out_stall_pct = 35;
      end
      budget = $urandom_range(40, 10);
      if (budget > RANDOM_ITEMS - rand_items) budget = RANDOM_ITEMS - rand_items;
      random_phase(budget);
      rand_items += budget;
      phase++;
    end

    drain();
    $display("Sent %0d text bytes (%0d from the directed table) under %0d random settings;",
             n_items, n_items - rand_items, phase);
    $display("compared %0d results, %0d field mismatches.", n_checked, mismatches);
    if (mismatches == 0) begin
      $display("[stream_find_and_replace_core] OK");
    end else begin
      $display("[stream_find_and_replace_core] ERROR");
    end
    $finish;
  end

endmodule

>>> stream_find_and_replace_core.f
rtl/core/sfr_pkg.sv
rtl/core/sfr_stream_if.sv
rtl/core/sfr_cell.sv
rtl/core/sfr_window.sv
rtl/core/stream_find_and_replace_core.sv
test/stream_find_and_replace_core_test.sv
